FILE: rtl/rsp_pkg.sv
// Shared constants, command and register codes, and types of the RLE sprite decoder.
// Depends on nothing; the decoder and top level refer to it by scoped names, the testbench imports it.
package rsp_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int MAX_HEIGHT     = 1024;
	localparam int MAX_BODY_BYTES = 65536;

	localparam int CFG_DIM_W = 11;
	localparam int CFG_LEN_W = 16;
	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int LEVEL_W   = 6;
	localparam int COORD_W   = 10;
	localparam int ARGB_W    = 32;
	localparam int PAL_W     = 3 * LEVEL_W;
	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int CFG_IDX_W = 2;

	// Column and row counters must hold the largest clamped dimension and the raw register.
	localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
	localparam int DIM_W     = (DIM_BITS > CFG_DIM_W) ? DIM_BITS : CFG_DIM_W;

	localparam int POS_W     = $clog2(2 * MAX_BODY_BYTES);
	localparam int LEN_CMP_W = ((POS_W > CFG_LEN_W) ? POS_W : CFG_LEN_W) + 1;

	localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DATA    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH  = 2'd2;

	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam logic [ARGB_W-1:0] ARGB_OPAQUE = 32'hff00_0000;

	typedef struct packed {
		logic [CFG_DIM_W-1:0] image_width;
		logic [CFG_DIM_W-1:0] image_height;
		logic [CFG_LEN_W-1:0] body_length;
	} cfg_t;

	// What one decode step produces: at most a pixel and then a finished marker.
	typedef struct packed {
		logic               pixel;
		logic               finish;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
	} step_res_t;

endpackage

FILE: rtl/rsp_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
module rsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rsp_decoder.sv
// Row/run state machine of the RLE sprite decoder: one encoded byte per step.
// Depends on rsp_pkg.
module rsp_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [rsp_pkg::CMD_W-1:0]     command,
	input  logic [rsp_pkg::BYTE_W-1:0]    data_byte,
	input  rsp_pkg::cfg_t                 cfg,
	output rsp_pkg::step_res_t            res
);

	localparam int DIM_W     = rsp_pkg::DIM_W;
	localparam int POS_W     = rsp_pkg::POS_W;
	localparam int LEN_CMP_W = rsp_pkg::LEN_CMP_W;
	localparam int BYTE_W    = rsp_pkg::BYTE_W;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(2 * rsp_pkg::MAX_BODY_BYTES - 1);

	typedef enum logic [2:0] {
		PH_COUNT,
		PH_SKIP,
		PH_SOLID,
		PH_PIXELS,
		PH_DONE
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [DIM_W-1:0]    row_q, row_d;
	logic [DIM_W-1:0]    col_q, col_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [POS_W-1:0]    row_start_q, row_start_d;
	logic [BYTE_W-1:0]   count_q, count_d;
	logic [BYTE_W-1:0]   solid_q, solid_d;

	logic [DIM_W-1:0]     eff_width;
	logic [DIM_W-1:0]     eff_height;
	logic [DIM_W-1:0]     width_ext;
	logic [DIM_W-1:0]     height_ext;
	logic [LEN_CMP_W-1:0] body_len;
	logic [POS_W-1:0]     pos_next;

	logic take_count, after_solids, end_row, next_row, finish, pixel;

	assign width_ext  = DIM_W'(cfg.image_width);
	assign height_ext = DIM_W'(cfg.image_height);
	assign eff_width  = (width_ext > DIM_W'(rsp_pkg::MAX_WIDTH))
	                    ? DIM_W'(rsp_pkg::MAX_WIDTH) : width_ext;
	assign eff_height = (height_ext > DIM_W'(rsp_pkg::MAX_HEIGHT))
	                    ? DIM_W'(rsp_pkg::MAX_HEIGHT) : height_ext;
	assign body_len   = LEN_CMP_W'(cfg.body_length);
	// Saturating byte position advance
	assign pos_next   = (pos_q < POS_LIMIT) ? pos_q + POS_W'(1) : pos_q;

	always_comb begin
		phase_d      = phase_q;
		row_d        = row_q;
		col_d        = col_q;
		pos_d        = pos_q;
		row_start_d  = row_start_q;
		count_d      = count_q;
		solid_d      = solid_q;
		take_count   = 1'b0;
		after_solids = 1'b0;
		end_row      = 1'b0;
		next_row     = 1'b0;
		finish       = 1'b0;
		pixel        = 1'b0;

		if (step) begin
			unique case (command)
				rsp_pkg::CMD_START: begin
					phase_d     = PH_COUNT;
					row_d       = '0;
					col_d       = '0;
					pos_d       = '0;
					row_start_d = '0;
					count_d     = '0;
					solid_d     = '0;
				end
				rsp_pkg::CMD_DATA: begin
					unique case (phase_q)
						PH_COUNT: begin
							take_count = 1'b1;
						end
						PH_SKIP: begin
							if ((DIM_W + 1)'(col_q) + (DIM_W + 1)'(data_byte)
							    >= (DIM_W + 1)'(eff_width)) begin
								// Skip reaches the edge: reuse this byte as the next row count
								if (LEN_CMP_W'(pos_q) + LEN_CMP_W'(1) >= body_len) begin
									finish = 1'b1;
								end else begin
									row_d = row_q + DIM_W'(1);
									if (row_d >= eff_height) begin
										finish = 1'b1;
									end else begin
										take_count = 1'b1;
									end
								end
							end else begin
								col_d   = col_q + DIM_W'(data_byte);
								pos_d   = pos_next;
								phase_d = PH_SOLID;
							end
						end
						PH_SOLID: begin
							pos_d = pos_next;
							if (data_byte == '0) begin
								after_solids = 1'b1;
							end else begin
								solid_d = data_byte;
								phase_d = PH_PIXELS;
							end
						end
						PH_PIXELS: begin
							// Drop pixels past the width but still consume them
							if (col_q < eff_width) begin
								pixel = 1'b1;
								col_d = col_q + DIM_W'(1);
							end
							pos_d   = pos_next;
							solid_d = solid_q - BYTE_W'(1);
							if (solid_d == '0) begin
								after_solids = 1'b1;
							end
						end
						PH_DONE: begin
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end

		if (take_count) begin
			if (row_d >= eff_height) begin
				finish = 1'b1;
			end else begin
				row_start_d = pos_q;
				pos_d       = pos_next;
				count_d     = data_byte;
				if (data_byte == '0) begin
					next_row = 1'b1;
				end else begin
					col_d   = '0;
					phase_d = PH_SKIP;
				end
			end
		end

		if (after_solids) begin
			if (col_d >= eff_width || (pos_d - row_start_q) >= POS_W'(count_q)) begin
				end_row = 1'b1;
			end else begin
				phase_d = PH_SKIP;
			end
		end

		if (end_row) begin
			if (LEN_CMP_W'(pos_d) + LEN_CMP_W'(1) >= body_len) begin
				finish = 1'b1;
			end else begin
				next_row = 1'b1;
			end
		end

		if (next_row) begin
			row_d = row_d + DIM_W'(1);
			if (row_d >= eff_height) begin
				finish = 1'b1;
			end else begin
				phase_d = PH_COUNT;
			end
		end

		if (finish) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_COUNT;
			row_q       <= '0;
			col_q       <= '0;
			pos_q       <= '0;
			row_start_q <= '0;
			count_q     <= '0;
			solid_q     <= '0;
		end else begin
			phase_q     <= phase_d;
			row_q       <= row_d;
			col_q       <= col_d;
			pos_q       <= pos_d;
			row_start_q <= row_start_d;
			count_q     <= count_d;
			solid_q     <= solid_d;
		end
	end

	assign res.pixel  = pixel;
	assign res.finish = finish;
	assign res.column = col_q[rsp_pkg::COORD_W-1:0];
	assign res.row    = row_q[rsp_pkg::COORD_W-1:0];

endmodule

FILE: rtl/rle_sprite_palette_decoder.sv
// Top level of the RLE sprite decoder: config registers, palette RAM, result queue.
// Depends on rsp_pkg, rsp_ram and rsp_decoder.
//
// The block takes one input transaction per cycle while in_ready is high: palette writes,
// encoded data bytes and image restarts all enter back to back. Row and run decoding is
// settled in the cycle a byte is accepted; the palette RAM read completes on the following
// edge, and the colour-expanded result enters a four-entry result queue, so a result is
// offered only after the stage 1 register and the queue. A byte that ends the image on its
// last pixel yields two results (the pixel, then the finished marker), which the queue
// absorbs; input ready drops only while the queue cannot take two more results.
module rle_sprite_palette_decoder (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [rsp_pkg::CMD_W-1:0]       command,
	input  logic [rsp_pkg::BYTE_W-1:0]      data_byte,
	input  logic [rsp_pkg::PAL_AW-1:0]      palette_index,
	input  logic [rsp_pkg::LEVEL_W-1:0]     red_level,
	input  logic [rsp_pkg::LEVEL_W-1:0]     green_level,
	input  logic [rsp_pkg::LEVEL_W-1:0]     blue_level,

	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            kind,
	output logic [rsp_pkg::COORD_W-1:0]     column,
	output logic [rsp_pkg::COORD_W-1:0]     row,
	output logic [rsp_pkg::ARGB_W-1:0]      argb,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rsp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rsp_pkg::CFG_LEN_W-1:0]   cfg_data
);

	localparam int RES_DEPTH = 4;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 3);
	localparam int COORD_W   = rsp_pkg::COORD_W;
	localparam int LEVEL_W   = rsp_pkg::LEVEL_W;

	typedef struct packed {
		logic                      kind;
		logic [COORD_W-1:0]        column;
		logic [COORD_W-1:0]        row;
		logic [rsp_pkg::ARGB_W-1:0] argb;
	} result_t;

	rsp_pkg::cfg_t       cfg_q;
	rsp_pkg::step_res_t  step_res;

	logic                       in_fire;
	logic [rsp_pkg::PAL_W-1:0]  pal_rdata;
	logic [rsp_pkg::ARGB_W-1:0] pixel_argb;

	logic               pixel_s1;
	logic               finish_s1;
	logic [COORD_W-1:0] column_s1;
	logic [COORD_W-1:0] row_s1;

	result_t            queue_q [RES_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W-1:0]   wr_ptr_2nd;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   push_n;
	logic               pop;
	result_t            head;

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= rsp_pkg::CFG_DIM_W'(1);
			cfg_q.image_height <= rsp_pkg::CFG_DIM_W'(1);
			cfg_q.body_length  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rsp_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data[rsp_pkg::CFG_DIM_W-1:0];
				rsp_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data[rsp_pkg::CFG_DIM_W-1:0];
				rsp_pkg::CFG_BODY_LENGTH:  cfg_q.body_length  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rsp_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_fire),
		.command   (command),
		.data_byte (data_byte),
		.cfg       (cfg_q),
		.res       (step_res)
	);

	rsp_ram #(
		.WIDTH (rsp_pkg::PAL_W),
		.DEPTH (rsp_pkg::PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (in_fire && command == rsp_pkg::CMD_PALETTE),
		.waddr (palette_index),
		.wdata ({red_level, green_level, blue_level}),
		.re    (in_fire && command == rsp_pkg::CMD_DATA),
		.raddr (data_byte),
		.rdata (pal_rdata)
	);

	// Stage 1: decode outcome waits here for the palette read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_s1  <= 1'b0;
			finish_s1 <= 1'b0;
		end else begin
			pixel_s1  <= step_res.pixel;
			finish_s1 <= step_res.finish;
		end
	end

	always_ff @(posedge clk) begin
		column_s1 <= step_res.column;
		row_s1    <= step_res.row;
	end

	// Scale each 6-bit component by four and force alpha opaque
	assign pixel_argb = rsp_pkg::ARGB_OPAQUE |
	                    {8'h00,
	                     pal_rdata[3*LEVEL_W-1:2*LEVEL_W], 2'b00,
	                     pal_rdata[2*LEVEL_W-1:LEVEL_W],   2'b00,
	                     pal_rdata[LEVEL_W-1:0],           2'b00};

	// Result queue: the stage 1 results always fit, ready holds back room for two
	assign push_n     = CNT_W'(pixel_s1) + CNT_W'(finish_s1);
	assign pop        = out_valid && out_ready;
	assign wr_ptr_2nd = wr_ptr_q + PTR_W'(pixel_s1);
	assign in_ready   = (count_q + push_n) <= CNT_W'(RES_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + push_n - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_s1) begin
			queue_q[wr_ptr_q] <= '{kind: rsp_pkg::KIND_PIXEL, column: column_s1,
			                       row: row_s1, argb: pixel_argb};
		end
		if (finish_s1) begin
			queue_q[wr_ptr_2nd] <= '{kind: rsp_pkg::KIND_FINISH, column: '0,
			                         row: '0, argb: '0};
		end
	end

	assign head      = queue_q[rd_ptr_q];
	assign out_valid = count_q != '0;
	assign kind      = head.kind;
	assign column    = head.column;
	assign row       = head.row;
	assign argb      = head.argb;

`ifndef SYNTHESIS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(RES_DEPTH))
		else $error("result queue count beyond its depth");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q + push_n) <= CNT_W'(RES_DEPTH))
		else $error("stage 1 results overflow the result queue");

	a_no_result_for_control: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && command != rsp_pkg::CMD_DATA |=> !pixel_s1 && !finish_s1)
		else $error("non-data transaction produced a result");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CNT_W'(RES_DEPTH - 1) |-> !in_ready)
		else $error("input accepted without room for two results");
`endif

endmodule

FILE: tb/sv/tb_rle_sprite_palette_decoder.sv
// Self-checking testbench for the RLE sprite palette decoder: palette loads, row/run decoding
// and the finished marker, checked against an in-bench predictor and a result scoreboard.
// Depends on rsp_pkg and the rle_sprite_palette_decoder top level.
module tb_rle_sprite_palette_decoder;
	import rsp_pkg::*;

	localparam int CLK_PERIOD     = 12;
	localparam int TIMEOUT_CYCLES = 500000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int MAX_REPORTS    = 10;
	localparam int PHASE_ITEMS    = 240;
	localparam int RGB_W          = 3 * (LEVEL_W + 2);
	localparam int SPARE_W        = CFG_LEN_W - CFG_DIM_W;
	localparam int POS_CEIL       = 2 * MAX_BODY_BYTES - 1;

	localparam logic [CMD_W-1:0]     CMD_UNUSED      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

	typedef enum logic [2:0] {
		WANT_COUNT,
		WANT_SKIP,
		WANT_SOLID,
		IN_PIXELS,
		IMAGE_DONE
	} decode_phase_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [BYTE_W-1:0]  data_byte;
		logic [PAL_AW-1:0]  palette_index;
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} sprite_cmd_t;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [ARGB_W-1:0]  argb;
	} sprite_result_t;

	typedef logic [BYTE_W-1:0] byte_q_t [$];

	// Tracks the decoder state and holds the pixels and markers still owed by the block.
	class pixel_scoreboard;
		logic [CFG_DIM_W-1:0] img_width  = 1;
		logic [CFG_DIM_W-1:0] img_height = 1;
		logic [CFG_LEN_W-1:0] body_len   = 0;
		logic [RGB_W-1:0]     palette [PAL_DEPTH];
		decode_phase_t        phase = WANT_COUNT;
		logic [DIM_W-1:0]     cur_row = '0;
		logic [DIM_W-1:0]     cur_col = '0;
		logic [POS_W-1:0]     pos = '0;
		logic [POS_W-1:0]     row_start = '0;
		logic [BYTE_W-1:0]    row_count = '0;
		logic [BYTE_W-1:0]    solid_left = '0;
		sprite_result_t       expected_px [$];
		int                   failures = 0;

		function int pending();
			return expected_px.size();
		endfunction

		function int width_used();
			return (int'(img_width) > MAX_WIDTH) ? MAX_WIDTH : int'(img_width);
		endfunction

		function int height_used();
			return (int'(img_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_height);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_LEN_W-1:0] value);
			case (idx)
				CFG_IMAGE_WIDTH:  img_width = value[CFG_DIM_W-1:0];
				CFG_IMAGE_HEIGHT: img_height = value[CFG_DIM_W-1:0];
				CFG_BODY_LENGTH:  body_len = value;
				default: ;
			endcase
		endfunction

		function void push_expect(logic k, logic [DIM_W-1:0] c, logic [DIM_W-1:0] r,
				logic [ARGB_W-1:0] a);
			sprite_result_t want;
			want.kind = k;
			want.column = c[COORD_W-1:0];
			want.row = r[COORD_W-1:0];
			want.argb = a;
			expected_px.push_back(want);
		endfunction

		function void close_image();
			phase = IMAGE_DONE;
			push_expect(KIND_FINISH, '0, '0, '0);
		endfunction

		function void step_position();
			if (int'(pos) < POS_CEIL) pos = pos + POS_W'(1);
		endfunction

		function void advance_row();
			cur_row = cur_row + DIM_W'(1);
			if (cur_row >= height_used()) close_image();
			else phase = WANT_COUNT;
		endfunction

		function void close_row();
			if (int'(pos) + 1 >= int'(body_len)) close_image();
			else advance_row();
		endfunction

		function void open_row(logic [BYTE_W-1:0] b);
			if (cur_row >= height_used()) begin
				close_image();
				return;
			end
			row_start = pos;
			step_position();
			row_count = b;
			if (b == 0) begin
				advance_row();
			end else begin
				cur_col = '0;
				phase = WANT_SKIP;
			end
		endfunction

		// A row closes on a full width or once its byte budget is spent.
		function void end_of_run();
			if (cur_col >= width_used() || int'(pos) - int'(row_start) >= int'(row_count))
				close_row();
			else
				phase = WANT_SKIP;
		endfunction

		function void note_input(sprite_cmd_t it);
			logic [BYTE_W-1:0] b;
			b = it.data_byte;
			case (it.command)
				CMD_PALETTE: begin
					palette[it.palette_index] = {it.red_level, 2'b00, it.green_level, 2'b00,
						it.blue_level, 2'b00};
				end
				CMD_START: begin
					phase = WANT_COUNT;
					cur_row = '0;
					cur_col = '0;
					pos = '0;
					row_start = '0;
					row_count = '0;
					solid_left = '0;
				end
				CMD_DATA: begin
					case (phase)
						WANT_COUNT: open_row(b);
						WANT_SKIP: begin
							// A skip reaching the width ends the row and becomes the next count.
							if (int'(cur_col) + int'(b) >= width_used()) begin
								if (int'(pos) + 1 >= int'(body_len)) begin
									close_image();
								end else begin
									cur_row = cur_row + DIM_W'(1);
									if (cur_row >= height_used()) close_image();
									else open_row(b);
								end
							end else begin
								cur_col = cur_col + DIM_W'(b);
								step_position();
								phase = WANT_SOLID;
							end
						end
						WANT_SOLID: begin
							step_position();
							if (b == 0) begin
								end_of_run();
							end else begin
								solid_left = b;
								phase = IN_PIXELS;
							end
						end
						IN_PIXELS: begin
							// Drop pixels past the width but still consume them.
							if (cur_col < width_used()) begin
								push_expect(KIND_PIXEL, cur_col, cur_row,
									ARGB_OPAQUE | {8'h00, palette[b]});
								cur_col = cur_col + DIM_W'(1);
							end
							step_position();
							solid_left = solid_left - BYTE_W'(1);
							if (solid_left == 0) end_of_run();
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		endfunction

		function void check_result(sprite_result_t got);
			sprite_result_t want;
			if (expected_px.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: unexpected result: kind %0d column %0d row %0d argb %08h",
						$time, got.kind, got.column, got.row, got.argb);
				return;
			end
			want = expected_px.pop_front();
			if (got.kind !== want.kind || got.column !== want.column || got.row !== want.row ||
					got.argb !== want.argb) begin
				failures++;
				if (failures <= MAX_REPORTS) begin
					$display("%0t: result mismatch: expected kind %0d column %0d row %0d argb %08h",
						$time, want.kind, want.column, want.row, want.argb);
					$display("%0t:                  actual kind %0d column %0d row %0d argb %08h",
						$time, got.kind, got.column, got.row, got.argb);
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [BYTE_W-1:0]    data_byte = '0;
	logic [PAL_AW-1:0]    palette_index = '0;
	logic [LEVEL_W-1:0]   red_level = '0;
	logic [LEVEL_W-1:0]   green_level = '0;
	logic [LEVEL_W-1:0]   blue_level = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 kind;
	logic [COORD_W-1:0]   column;
	logic [COORD_W-1:0]   row;
	logic [ARGB_W-1:0]    argb;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_LEN_W-1:0] cfg_data = '0;

	pixel_scoreboard sb;
	int gap_pct = 0;
	int stall_pct = 0;
	int data_items = 0;

	rle_sprite_palette_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.data_byte    (data_byte),
		.palette_index(palette_index),
		.red_level    (red_level),
		.green_level  (green_level),
		.blue_level   (blue_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.column       (column),
		.row          (row),
		.argb         (argb),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= stall_pct);
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
			sb.check_result({kind, column, row, argb});
	end

	function automatic int min_int(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	function automatic sprite_cmd_t make_item(input logic [CMD_W-1:0] cmd,
			input logic [BYTE_W-1:0] b);
		sprite_cmd_t it;
		it.command = cmd;
		it.data_byte = b;
		it.palette_index = PAL_AW'($urandom_range(0, PAL_DEPTH - 1));
		it.red_level = LEVEL_W'($urandom_range(0, 63));
		it.green_level = LEVEL_W'($urandom_range(0, 63));
		it.blue_level = LEVEL_W'($urandom_range(0, 63));
		return it;
	endfunction

	function automatic logic [CFG_LEN_W-1:0] dim_word(input int v);
		logic [SPARE_W-1:0] spare;
		spare = ($urandom_range(0, 3) == 0) ? SPARE_W'($urandom) : '0;
		return {spare, CFG_DIM_W'(v)};
	endfunction

	// Well-formed rows: count byte, skip/solid pairs, indexes; now and then a row closed by
	// an oversized skip that doubles as the next row's count.
	function automatic byte_q_t build_rows(input int w_eff, input int rows);
		byte_q_t q;
		int cnt;
		int carried;
		int len;
		int col;
		int s;
		int n;
		carried = -1;
		for (int r = 0; r < rows; r++) begin
			if (carried >= 0) begin
				cnt = carried;
				carried = -1;
			end else begin
				if ($urandom_range(0, 9) == 0) cnt = 0;
				else if ($urandom_range(0, 29) == 0) cnt = $urandom_range(3, 255);
				else cnt = $urandom_range(3, 20);
				q.push_back(BYTE_W'(cnt));
			end
			len = 1;
			col = 0;
			while (len < cnt && col < w_eff) begin
				if (r < rows - 1 && w_eff - col <= 255 && $urandom_range(0, 11) == 0) begin
					s = $urandom_range(w_eff - col, min_int(255, w_eff - col + 20));
					q.push_back(BYTE_W'(s));
					carried = s;
					break;
				end
				s = $urandom_range(0, min_int(w_eff - col - 1, 6));
				q.push_back(BYTE_W'(s));
				col += s;
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 5);
				q.push_back(BYTE_W'(n));
				len += 2 + n;
				for (int k = 0; k < n; k++) begin
					q.push_back(BYTE_W'($urandom_range(0, 255)));
					col++;
				end
			end
		end
		return q;
	endfunction

	task automatic send_command(input sprite_cmd_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= it.command;
		data_byte <= it.data_byte;
		palette_index <= it.palette_index;
		red_level <= it.red_level;
		green_level <= it.green_level;
		blue_level <= it.blue_level;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_input(it);
		if (it.command == CMD_DATA || it.command == CMD_PALETTE) data_items++;
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_LEN_W-1:0] value, input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (last) cfg_valid <= 1'b0;
		sb.set_register(idx, value);
	endtask

	// Hold the sender until every owed result is out, then let in-flight bytes settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_palette();
		sprite_cmd_t it;
		for (int i = 0; i < PAL_DEPTH; i++) begin
			it = make_item(CMD_PALETTE, BYTE_W'($urandom_range(0, 255)));
			it.palette_index = PAL_AW'(i);
			if (i == 0) begin
				it.red_level = '0;
				it.green_level = '0;
				it.blue_level = '0;
			end else if (i == PAL_DEPTH - 1) begin
				it.red_level = '1;
				it.green_level = '1;
				it.blue_level = '1;
			end
			send_command(it);
		end
	endtask

	task automatic run_directed();
		byte_q_t walk;
		wait_idle();
		write_register(CFG_SPARE_INDEX, 16'hffff, 1'b0);
		write_register(CFG_IMAGE_WIDTH, 16'd8, 1'b0);
		write_register(CFG_IMAGE_HEIGHT, 16'd4, 1'b0);
		write_register(CFG_BODY_LENGTH, 16'd60, 1'b1);
		send_command(make_item(CMD_START, 8'hff));
		send_command(make_item(CMD_UNUSED, 8'h5a));
		// Empty row, runs spilling past the width, a skip reused as count, a byte after the end.
		walk = '{8'd0, 8'd9, 8'd2, 8'd3, 8'd0, 8'd128, 8'd17, 8'd0, 8'd0, 8'd1, 8'd4,
			8'd255, 8'd64, 8'd1, 8'd2, 8'd20, 8'd9, 8'd3, 8'd1, 8'd255, 8'd5, 8'd7};
		foreach (walk[i]) send_command(make_item(CMD_DATA, walk[i]));

		// Height lowered under the current row: the next count byte finishes the image.
		wait_idle();
		send_command(make_item(CMD_START, 8'h00));
		send_command(make_item(CMD_DATA, 8'd0));
		wait_idle();
		write_register(CFG_IMAGE_HEIGHT, 16'd1, 1'b1);
		send_command(make_item(CMD_DATA, 8'd5));

		// Last pixel of the last row yields the pixel and the marker together.
		wait_idle();
		write_register(CFG_IMAGE_WIDTH, 16'd2, 1'b0);
		write_register(CFG_BODY_LENGTH, 16'hffff, 1'b1);
		send_command(make_item(CMD_START, 8'h00));
		walk = '{8'd4, 8'd0, 8'd2, 8'd0, 8'd255};
		foreach (walk[i]) send_command(make_item(CMD_DATA, walk[i]));
	endtask

	task automatic run_image();
		byte_q_t stream;
		int w_reg;
		int h_reg;
		int rows;
		int len_reg;
		int split;
		int pick;
		wait_idle();
		case ($urandom_range(0, 19))
			0: w_reg = 0;
			1: w_reg = 1;
			2: w_reg = MAX_WIDTH;
			3: w_reg = 2047;
			4: w_reg = $urandom_range(17, MAX_WIDTH - 1);
			default: w_reg = $urandom_range(2, 16);
		endcase
		case ($urandom_range(0, 19))
			0: h_reg = 0;
			1: h_reg = MAX_HEIGHT;
			2: h_reg = 2047;
			3: h_reg = $urandom_range(7, 40);
			default: h_reg = $urandom_range(1, 6);
		endcase
		rows = min_int((h_reg == 0) ? 1 : min_int(h_reg, MAX_HEIGHT), $urandom_range(1, 6));
		stream = build_rows(min_int(w_reg, MAX_WIDTH), rows);
		// Break a few images with stray bytes.
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 3))
				stream[$urandom_range(0, stream.size() - 1)] = BYTE_W'($urandom_range(0, 255));
		end
		pick = $urandom_range(0, 9);
		if (pick < 5) len_reg = stream.size();
		else if (pick < 7) len_reg = 65535;
		else if (pick == 7) len_reg = $urandom_range(0, stream.size());
		else if (pick == 8) len_reg = 0;
		else len_reg = stream.size() + $urandom_range(1, 3);
		write_register(CFG_IMAGE_WIDTH, dim_word(w_reg), 1'b0);
		write_register(CFG_IMAGE_HEIGHT, dim_word(h_reg), 1'b0);
		write_register(CFG_BODY_LENGTH, CFG_LEN_W'(len_reg), 1'b1);
		if ($urandom_range(0, 19) != 0)
			send_command(make_item(CMD_START, BYTE_W'($urandom_range(0, 255))));
		split = ($urandom_range(0, 7) == 0) ? $urandom_range(0, stream.size() - 1) : -1;
		foreach (stream[i]) begin
			if (i == split) begin
				wait_idle();
				write_register(CFG_IMAGE_HEIGHT, dim_word($urandom_range(0, 4)), 1'b1);
			end
			if ($urandom_range(0, 24) == 0)
				send_command(make_item(CMD_PALETTE, BYTE_W'($urandom_range(0, 255))));
			if ($urandom_range(0, 59) == 0)
				send_command(make_item(CMD_UNUSED, BYTE_W'($urandom_range(0, 255))));
			send_command(make_item(CMD_DATA, stream[i]));
		end
		repeat ($urandom_range(0, 2))
			send_command(make_item(CMD_DATA, BYTE_W'($urandom_range(0, 255))));
	endtask

	task automatic run_phase(input int gap, input int stall, input int items);
		int quota;
		gap_pct = gap;
		stall_pct = stall;
		quota = data_items + items;
		while (data_items < quota) run_image();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_palette();
		run_directed();
		run_phase(0, 0, PHASE_ITEMS);
		run_phase(79, 0, PHASE_ITEMS);
		run_phase(0, 79, PHASE_ITEMS);
		run_phase(29, 29, PHASE_ITEMS);
		wait_idle();
		if (sb.failures == 0 && sb.pending() == 0)
			$display("rle_sprite_palette_decoder test passed");
		else
			$display("rle_sprite_palette_decoder test failed");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("rle_sprite_palette_decoder test failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rsp_pkg.sv
rtl/rsp_ram.sv
rtl/rsp_decoder.sv
rtl/rle_sprite_palette_decoder.sv
tb/sv/tb_rle_sprite_palette_decoder.sv
